// ===== src/sps_pkg.sv =====
// Shared constants and types for the segmented prime sieve.
// No dependencies; every other file imports this package.
package sps_pkg;

  localparam int unsigned WindowSize = 4096;
  localparam int unsigned AddrW      = $clog2(WindowSize);
  localparam int unsigned ValW       = 32;
  localparam int unsigned CurW       = ValW + 1;   // cursor/multiple may pass the top
  localparam int unsigned DivW       = 17;         // divisor never exceeds 2**16
  localparam int unsigned DivCntW    = $clog2(ValW);

  localparam logic ActStart = 1'b0;
  localparam logic ActNext  = 1'b1;

  typedef enum logic [1:0] {
    StPrime    = 2'd0,
    StNoMore   = 2'd1,
    StSieved   = 2'd2,
    StRejected = 2'd3
  } status_e;

endpackage

// ===== src/sps_if.sv =====
// Valid/ready channel interfaces for the sieve: request word and result word.
// Depends on sps_pkg for field widths.
interface sps_in_if import sps_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            action;
  logic [ValW-1:0] low_bound;
  logic [ValW-1:0] high_bound;

  modport source (output valid, action, low_bound, high_bound, input ready);
  modport sink   (input valid, action, low_bound, high_bound, output ready);
endinterface

interface sps_out_if import sps_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ValW-1:0] prime_value;
  logic [1:0]      status;

  modport source (output valid, prime_value, status, input ready);
  modport sink   (input valid, prime_value, status, output ready);
endinterface

// ===== src/sps_rem_unit.sv =====
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on sps_pkg.
module sps_rem_unit import sps_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ValW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] rem_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [ValW-1:0]    quo_q;
  logic [DivW-1:0]    div_q;
  logic [DivW-1:0]    rem_q;
  logic [DivW:0]      trial;
  logic [DivW:0]      diff;

  assign trial = {rem_q, quo_q[ValW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(ValW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[ValW-2:0], 1'b0};
      // remainder stays below the divisor, so the low bits hold it
      if (trial >= {1'b0, div_q}) rem_q <= diff[DivW-1:0];
      else                        rem_q <= trial[DivW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/segmented_prime_sieve.sv =====
// Segmented prime sieve: request channel in_i, result channel out_o.
// A start word (action 0) carries low_bound/high_bound; the block answers with
// status 3 (rejected) when high < low or the window spans more than WindowSize
// values, else sieves the window and answers status 2. Each next word
// (action 1) answers with the next unmarked value >= max(2, low) and status 0,
// or status 1 once the window is exhausted or none was sieved.
// Sequence: a rejected start or a next with nothing left goes from Idle through
// Done to the result register. An accepted start clears the window in Clear,
// then for each divisor d with d*d <= high checks d in DivChk, waits in DivWait
// on the bit-serial remainder unit, and marks one multiple per Mark step, the
// last Mark step moving on to the next d. A next word tests each value in the
// mark RAM through ScanRd and ScanChk.
// One word is worked on at a time; in_i.ready is high only when the sequencer
// is idle. The result sits in an output register; while the receiver stalls
// the block may take the next word, but holds its own result until the
// register drains. Reset leaves no window sieved; the mark RAM is not cleared
// at reset since each start clears its own window.
module segmented_prime_sieve import sps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sps_in_if.sink    in_i,
  sps_out_if.source out_o
);

  typedef enum logic [2:0] {
    Idle, Clear, DivChk, DivWait, Mark, ScanRd, ScanChk, Done
  } state_e;

  state_e          state_q;
  logic [ValW-1:0] base_q, top_q;
  logic [AddrW-1:0] idx_q, span_q;
  logic [DivW-1:0] d_q;
  logic [CurW-1:0] sq_q, m_q, cursor_q;
  logic            win_ready_q;
  logic [ValW-1:0] res_val_q;
  status_e         res_st_q;
  logic            out_valid_q;
  logic [ValW-1:0] out_val_q;
  status_e         out_st_q;

  // mark RAM
  logic             marks_q [WindowSize];
  logic             rd_q;
  logic             mem_we, mem_wdata;
  logic [AddrW-1:0] mem_waddr, mem_raddr;

  logic            div_start, div_done;
  logic [DivW-1:0] rem;
  logic [CurW-1:0] first, m_start, cursor_inc, cur_off;
  logic [ValW-1:0] span_diff;
  logic            reject;

  sps_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (base_q),
    .divisor_i  (d_q),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign span_diff  = in_i.high_bound - in_i.low_bound;
  assign reject     = (in_i.high_bound < in_i.low_bound) ||
                      (span_diff >= ValW'(WindowSize));
  assign cursor_inc = cursor_q + 1'b1;
  assign cur_off    = cursor_q - {1'b0, base_q};

  // first multiple of d at or above the base, then no lower than d*d
  always_comb begin
    first = {1'b0, base_q};
    if (rem != '0) first = {1'b0, base_q} + CurW'(d_q - rem);
    m_start = (first > sq_q) ? first : sq_q;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 1'b0;
    mem_waddr = idx_q;
    div_start = 1'b0;
    case (state_q)
      Clear: mem_we = 1'b1;
      DivChk: div_start = (sq_q <= {1'b0, top_q});
      Mark: begin
        mem_we    = (m_q <= {1'b0, top_q});
        mem_wdata = 1'b1;
        mem_waddr = m_q[AddrW-1:0] - base_q[AddrW-1:0];
      end
      default: ;
    endcase
  end

  assign mem_raddr = cur_off[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) marks_q[mem_waddr] <= mem_wdata;
    rd_q <= marks_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      base_q      <= '0;
      top_q       <= '0;
      cursor_q    <= '0;
      win_ready_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      span_q      <= '0;
      d_q         <= '0;
      sq_q        <= '0;
      m_q         <= '0;
      res_val_q   <= '0;
      res_st_q    <= StNoMore;
      out_val_q   <= '0;
      out_st_q    <= StNoMore;
    end else begin
      // Done reloads the register itself when it drains in the same cycle
      if (out_valid_q && out_o.ready && state_q != Done) out_valid_q <= 1'b0;
      case (state_q)
        Idle: begin
          if (in_i.valid) begin
            res_val_q <= '0;
            if (in_i.action == ActStart) begin
              win_ready_q <= 1'b0;
              if (reject) begin
                res_st_q <= StRejected;
                state_q  <= Done;
              end else begin
                base_q  <= in_i.low_bound;
                top_q   <= in_i.high_bound;
                span_q  <= span_diff[AddrW-1:0];
                idx_q   <= '0;
                state_q <= Clear;
              end
            end else if (!win_ready_q || cursor_q > {1'b0, top_q}) begin
              res_st_q <= StNoMore;
              state_q  <= Done;
            end else begin
              state_q <= ScanRd;
            end
          end
        end
        Clear: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == span_q) begin
            d_q     <= DivW'(2);
            sq_q    <= CurW'(4);
            state_q <= DivChk;
          end
        end
        DivChk: begin
          if (sq_q > {1'b0, top_q}) begin
            cursor_q    <= (base_q < ValW'(2)) ? CurW'(2) : {1'b0, base_q};
            win_ready_q <= 1'b1;
            res_st_q    <= StSieved;
            state_q     <= Done;
          end else begin
            state_q <= DivWait;
          end
        end
        DivWait: begin
          if (div_done) begin
            m_q     <= m_start;
            state_q <= Mark;
          end
        end
        Mark: begin
          if (m_q > {1'b0, top_q}) begin
            // (d+1)^2 = d^2 + 2d + 1
            sq_q    <= sq_q + CurW'({d_q, 1'b1});
            d_q     <= d_q + 1'b1;
            state_q <= DivChk;
          end else begin
            m_q <= m_q + CurW'(d_q);
          end
        end
        ScanRd: state_q <= ScanChk;
        ScanChk: begin
          cursor_q <= cursor_inc;
          if (!rd_q) begin
            res_val_q <= cursor_q[ValW-1:0];
            res_st_q  <= StPrime;
            state_q   <= Done;
          end else if (cursor_inc > {1'b0, top_q}) begin
            res_st_q <= StNoMore;
            state_q  <= Done;
          end else begin
            state_q <= ScanRd;
          end
        end
        Done: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_val_q   <= res_val_q;
            out_st_q    <= res_st_q;
            state_q     <= Idle;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign in_i.ready        = (state_q == Idle);
  assign out_o.valid       = out_valid_q;
  assign out_o.prime_value = out_val_q;
  assign out_o.status      = out_st_q;

endmodule

// ===== src/sps_checker.sv =====
// Port-level checks for segmented_prime_sieve, attached by bind.
// Depends on sps_pkg for status codes.
module sps_checker import sps_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [ValW-1:0] prime_value_i,
  input logic [1:0]      status_i
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // words taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result word with no request outstanding");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q != 2'd2)
    else $error("request taken while two words outstanding");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != StPrime |-> prime_value_i == '0)
    else $error("nonzero value with non-prime status");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(prime_value_i) && $stable(status_i))
    else $error("stalled result word changed");

endmodule

bind segmented_prime_sieve sps_checker u_sps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .prime_value_i (out_o.prime_value),
  .status_i      (out_o.status)
);
